// ===== rtl/u8u16_pkg.sv =====
// Shared types, constants and helpers of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    // Replacement character, surrogate bases and code point limits
    localparam logic [15:0] C_REPL_UNIT = 16'hFFFD;
    localparam logic [15:0] C_HI_BASE   = 16'hD800;
    localparam logic [15:0] C_LO_BASE   = 16'hDC00;
    localparam logic [20:0] C_SUPP_BASE = 21'h010000;
    localparam logic [20:0] C_MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] C_MIN_2B    = 21'h000080;
    localparam logic [20:0] C_MIN_3B    = 21'h000800;
    localparam logic [20:0] C_SURR_LO   = 21'h00D800;
    localparam logic [20:0] C_SURR_HI   = 21'h00DFFF;

    // Sequence lengths held in the length register
    localparam logic [2:0] C_LEN_IDLE = 3'd0;
    localparam logic [2:0] C_LEN_2    = 3'd2;
    localparam logic [2:0] C_LEN_3    = 3'd3;
    localparam logic [2:0] C_LEN_4    = 3'd4;

    // Continuation bytes still expected
    localparam logic [1:0] C_PEND_NONE = 2'd0;
    localparam logic [1:0] C_PEND_ONE  = 2'd1;
    localparam logic [1:0] C_PEND_TWO  = 2'd2;
    localparam logic [1:0] C_PEND_THREE = 2'd3;

    // One UTF-16 result request
    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        terminator;
        logic        last_of_run;
    } t_result;

    function automatic t_result mk_result(input logic [15:0] unit, input logic repl,
                                          input logic term);
        t_result r;
        r.code_unit   = unit;
        r.replaced    = repl;
        r.terminator  = term;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/u8u16_in_if.sv =====
// Byte input channel: valid/ready handshake with one UTF-8 byte per request.
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/u8u16_out_if.sv =====
// Unit output channel: valid/ready handshake with one UTF-16 unit per request.
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        replaced;
    logic        terminator;
    logic        last_of_run;

    modport source (output valid, output code_unit, output replaced, output terminator,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input replaced, input terminator,
                    input last_of_run, output ready);
endinterface

// ===== rtl/utf8_to_utf16_decoder.sv =====
// A byte accepted into the input register is decoded from that register, and its units are
// written into the two-slot result buffer, whose slot 0 drives the output port.
// Throughput: one byte per cycle while no byte yields two units and the output is not stalled;
// two units (surrogate pair, or U+FFFD plus a unit) leave the single-unit port one at a time.
// Reset (synchronous, active low) empties both stages and closes any open sequence.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8u16_in_if.sink      i_in,
    u8u16_out_if.source   o_out
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state
    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_pend, n_pend;
    logic [2:0]  r_len, n_len;

    // Result buffer: two slots, slot 0 is presented
    t_result     r_slot [2];
    t_result     n_slot [2];
    logic [1:0]  r_cnt, n_cnt;

    // Decode results
    t_result     w_res [2];
    logic [1:0]  w_nres;
    logic        w_fire;
    logic        w_pop;
    logic [1:0]  w_rem;

    // Decode helpers
    logic        w_cont;
    logic [20:0] w_acc_sh;
    logic [19:0] w_t;
    logic        w_ok;
    logic        w_fresh;
    logic        w_lead;

    assign i_in.ready = !r_in_valid || w_fire;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Per-byte decode
    always_comb begin
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_len    = r_len;
        w_res[0] = '0;
        w_res[1] = '0;
        w_nres   = 2'd0;
        w_fresh  = 1'b0;
        w_lead   = 1'b0;
        w_cont   = (r_in_byte[7:6] == 2'b10);
        w_acc_sh = {r_acc[14:0], r_in_byte[5:0]};
        w_t      = 20'(w_acc_sh - C_SUPP_BASE);

        case (r_len)
            C_LEN_2: w_ok = (w_acc_sh >= C_MIN_2B);
            C_LEN_3: w_ok = (w_acc_sh >= C_MIN_3B)
                            && !((w_acc_sh >= C_SURR_LO) && (w_acc_sh <= C_SURR_HI));
            C_LEN_4: w_ok = (w_acc_sh >= C_SUPP_BASE) && (w_acc_sh <= C_MAX_CP);
            default: w_ok = 1'b0;
        endcase

        if (r_pend != C_PEND_NONE) begin
            if (w_cont) begin
                if (r_pend == C_PEND_ONE) begin
                    // sequence complete: check and emit
                    if (!w_ok) begin
                        w_res[0] = mk_result(C_REPL_UNIT, 1'b1, 1'b0);
                        w_nres   = 2'd1;
                    end else if (r_len == C_LEN_4) begin
                        w_res[0] = mk_result(C_HI_BASE + {6'd0, w_t[19:10]}, 1'b0, 1'b0);
                        w_res[1] = mk_result(C_LO_BASE + {6'd0, w_t[9:0]}, 1'b0, 1'b0);
                        w_nres   = 2'd2;
                    end else begin
                        w_res[0] = mk_result(w_acc_sh[15:0], 1'b0, 1'b0);
                        w_nres   = 2'd1;
                    end
                    n_acc  = '0;
                    n_pend = C_PEND_NONE;
                    n_len  = C_LEN_IDLE;
                end else if (r_in_last) begin
                    // truncated at end of input
                    w_res[0] = mk_result(C_REPL_UNIT, 1'b1, 1'b0);
                    w_nres   = 2'd1;
                    n_acc    = '0;
                    n_pend   = C_PEND_NONE;
                    n_len    = C_LEN_IDLE;
                end else begin
                    n_acc  = w_acc_sh;
                    n_pend = r_pend - 2'd1;
                end
            end else begin
                // broken sequence, then decode this byte afresh
                w_res[0] = mk_result(C_REPL_UNIT, 1'b1, 1'b0);
                w_nres   = 2'd1;
                n_acc    = '0;
                n_pend   = C_PEND_NONE;
                n_len    = C_LEN_IDLE;
                w_fresh  = 1'b1;
            end
        end else begin
            w_fresh = 1'b1;
        end

        if (w_fresh) begin
            if (r_in_byte == 8'h00) begin
                w_res[w_nres[0]] = mk_result(16'h0000, 1'b0, 1'b1);
                w_nres           = w_nres + 2'd1;
            end else if (!r_in_byte[7]) begin
                w_res[w_nres[0]] = mk_result({8'h00, r_in_byte}, 1'b0, 1'b0);
                w_nres           = w_nres + 2'd1;
            end else if (r_in_byte[7:5] == 3'b110) begin
                w_lead = 1'b1;
                n_acc  = {16'd0, r_in_byte[4:0]};
                n_len  = C_LEN_2;
                n_pend = C_PEND_ONE;
            end else if (r_in_byte[7:4] == 4'b1110) begin
                w_lead = 1'b1;
                n_acc  = {17'd0, r_in_byte[3:0]};
                n_len  = C_LEN_3;
                n_pend = C_PEND_TWO;
            end else if (r_in_byte[7:3] == 5'b11110) begin
                w_lead = 1'b1;
                n_acc  = {18'd0, r_in_byte[2:0]};
                n_len  = C_LEN_4;
                n_pend = C_PEND_THREE;
            end else begin
                w_res[w_nres[0]] = mk_result(C_REPL_UNIT, 1'b1, 1'b0);
                w_nres           = w_nres + 2'd1;
            end
            // a lead byte that is also the last byte of the input
            if (w_lead && r_in_last) begin
                w_res[w_nres[0]] = mk_result(C_REPL_UNIT, 1'b1, 1'b0);
                w_nres           = w_nres + 2'd1;
                n_acc            = '0;
                n_pend           = C_PEND_NONE;
                n_len            = C_LEN_IDLE;
            end
        end

        if (w_nres != 2'd0) begin
            w_res[1'(w_nres - 2'd1)].last_of_run = 1'b1;
        end
    end

    // Room check: a byte is decoded only if all its units fit in the buffer
    assign w_pop  = o_out.valid && o_out.ready;
    assign w_rem  = r_cnt - {1'b0, w_pop};
    assign w_fire = r_in_valid && (({1'b0, w_rem} + {1'b0, w_nres}) <= 3'd2);

    // Buffer next state
    always_comb begin
        n_slot[0] = r_slot[0];
        n_slot[1] = r_slot[1];
        if (w_pop) begin
            n_slot[0] = r_slot[1];
        end
        if (w_fire && (w_nres != 2'd0)) begin
            n_slot[w_rem[0]] = w_res[0];
        end
        if (w_fire && (w_nres == 2'd2)) begin
            n_slot[1] = w_res[1];
        end
        n_cnt = w_rem + (w_fire ? w_nres : 2'd0);
    end

    // State and buffer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= C_PEND_NONE;
            r_len  <= C_LEN_IDLE;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_fire) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_len  <= n_len;
            end
        end
        r_slot[0] <= n_slot[0];
        r_slot[1] <= n_slot[1];
    end

    // Output port
    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.code_unit   = r_slot[0].code_unit;
    assign o_out.replaced    = r_slot[0].replaced;
    assign o_out.terminator  = r_slot[0].terminator;
    assign o_out.last_of_run = r_slot[0].last_of_run;

endmodule

// ===== rtl/u8u16_checker.sv =====
// Port-level assertions for the UTF-8 to UTF-16 decoder, and their binding.
module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_code_unit,
    input logic        i_replaced,
    input logic        i_terminator,
    input logic        i_last_of_run
);

    // A stalled output request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_unit))
        else $error("output request dropped or changed while stalled");

    // Reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Terminator is a plain zero unit
    a_term_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_terminator |-> i_code_unit == 16'h0000 && !i_replaced
                                        && i_last_of_run)
        else $error("malformed terminator unit");

    // Replacement units carry U+FFFD
    a_repl_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_replaced |-> i_code_unit == 16'hFFFD && !i_terminator)
        else $error("replaced unit is not U+FFFD");

    // A high surrogate is always followed by its low half from the same byte
    a_hi_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_replaced && i_code_unit[15:10] == 6'b110110 |-> !i_last_of_run)
        else $error("high surrogate ends a run");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_u8u16_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_code_unit   (o_out.code_unit),
    .i_replaced    (o_out.replaced),
    .i_terminator  (o_out.terminator),
    .i_last_of_run (o_out.last_of_run)
);
